### rtl/hsv_to_rgb_convert_defines.svh
// Assertion macros shared by the HSV to RGB converter modules.
`ifndef HSV_TO_RGB_CONVERT_DEFINES_SVH
`define HSV_TO_RGB_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS

`define HSVRGB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hsvrgb: check failed");

`define HSVRGB_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`else

`define HSVRGB_ASSERT(lbl, clk, rst, prop)

`define HSVRGB_ASSERT_MSG(lbl, clk, rst, prop, msg)

`endif

`endif

### rtl/hsvrgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsvrgb_pkg;

   localparam int unsigned HSVRGB_FRAC_BITS   = 12;
   localparam int unsigned PIX_W              = 13;
   localparam int unsigned HSVRGB_QUEUE_DEPTH = 2;

   typedef logic [2:0] sector_type;

   // hue sectors, each 60 degrees wide
   localparam sector_type SEC_RED_YELLOW    = 3'd0;
   localparam sector_type SEC_YELLOW_GREEN  = 3'd1;
   localparam sector_type SEC_GREEN_CYAN    = 3'd2;
   localparam sector_type SEC_CYAN_BLUE     = 3'd3;
   localparam sector_type SEC_BLUE_MAGENTA  = 3'd4;
   localparam sector_type SEC_MAGENTA_RED   = 3'd5;

endpackage

### rtl/hsvrgb_req_if.sv
// Pixel input channel: hue, saturation and brightness with valid/ready.
`timescale 1ns / 1ps

interface hsvrgb_req_if import hsvrgb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] hue;
   logic [PIX_W-1:0] saturation;
   logic [PIX_W-1:0] brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

### rtl/hsvrgb_rsp_if.sv
// Pixel result channel: red, green and blue with valid/ready.
`timescale 1ns / 1ps

interface hsvrgb_rsp_if import hsvrgb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

### rtl/hsvrgb_queue.sv
// Short FIFO decoupling the classify stage from the arithmetic pipeline.
`timescale 1ns / 1ps
`include "hsv_to_rgb_convert_defines.svh"

module hsvrgb_queue import hsvrgb_pkg::*; #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned DEPTH = HSVRGB_QUEUE_DEPTH;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNTW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNTW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HSVRGB_ASSERT(a_q_count_bound, clock, reset, count_ff <= CNTW'(DEPTH))
   `HSVRGB_ASSERT_MSG(a_q_ptr_count, clock, reset, (wr_ptr_ff == rd_ptr_ff) == ((count_ff == '0) || (count_ff == CNTW'(DEPTH))), "hsvrgb: queue pointers disagree with count")

endmodule

### rtl/hsvrgb_front.sv
// Front stage: takes a pixel beat, clamps, wraps hue and splits it into sector and fraction.
`timescale 1ns / 1ps

module hsvrgb_front import hsvrgb_pkg::*; #(
   parameter int unsigned FRAC_BITS = HSVRGB_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   hsvrgb_req_if.sink                 req_chan,
   output logic                       ent_valid,
   input  logic                       ent_ready,
   output logic [3*FRAC_BITS+5:0]     ent_data
);

   localparam int unsigned CW = FRAC_BITS + 1;
   localparam int unsigned WW = (CW > PIX_W) ? CW : PIX_W;
   localparam int unsigned HW = FRAC_BITS + 3;
   localparam int unsigned EW = 3 * FRAC_BITS + 6;

   logic [WW-1:0]        one_w, h_w, s_w, v_w;
   logic [CW-1:0]        s_cl, v_cl;
   logic [FRAC_BITS-1:0] h_fx, frac;
   logic [HW-1:0]        h6;
   sector_type           sector;
   logic                 gray;
   logic                 accept;

   logic                 valid_ff, valid_in;
   logic [EW-1:0]        data_ff, data_in;

   assign one_w = WW'(1) << FRAC_BITS;
   assign h_w   = WW'(req_chan.hue);
   assign s_w   = WW'(req_chan.saturation);
   assign v_w   = WW'(req_chan.brightness);

   assign s_cl  = CW'((s_w > one_w) ? one_w : s_w);
   assign v_cl  = CW'((v_w > one_w) ? one_w : v_w);
   assign gray  = (s_cl == '0);

   // hue of one or more wraps to zero
   assign h_fx   = (h_w >= one_w) ? '0 : FRAC_BITS'(h_w);
   assign h6     = HW'({h_fx, 2'b00}) + HW'({h_fx, 1'b0});
   assign sector = sector_type'(h6[HW-1:FRAC_BITS]);
   assign frac   = h6[FRAC_BITS-1:0];

   assign req_chan.ready = !valid_ff || ent_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign valid_in = accept || (valid_ff && !ent_ready);
   assign data_in  = {gray, sector, frac, s_cl, v_cl};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign ent_valid = valid_ff;
   assign ent_data  = data_ff;

endmodule

### rtl/hsvrgb_back.sv
// Back pipeline: three products, two more products, then primary selection into the output register.
`timescale 1ns / 1ps
`include "hsv_to_rgb_convert_defines.svh"

module hsvrgb_back import hsvrgb_pkg::*; #(
   parameter int unsigned FRAC_BITS = HSVRGB_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       ent_valid,
   output logic                       ent_ready,
   input  logic [3*FRAC_BITS+5:0]     ent_data,
   hsvrgb_rsp_if.source               rsp_chan
);

   localparam int unsigned CW = FRAC_BITS + 1;
   localparam int unsigned PW = 2 * CW;
   localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // unpacked queue entry
   logic                 e_gray;
   sector_type           e_sector;
   logic [FRAC_BITS-1:0] e_frac;
   logic [CW-1:0]        e_sat, e_val;

   logic                 out_ready, s2_ready, s1_ready;

   // stage 1: S*F, S*(1-F), V*(1-S)
   logic [CW-1:0] omf, oms;
   logic [PW-1:0] p_sf, p_sg, p_m;
   logic          s1_valid_ff;
   logic          s1_gray_ff;
   sector_type    s1_sector_ff;
   logic [CW-1:0] s1_val_ff, s1_sf_ff, s1_sg_ff, s1_m_ff;
   logic [CW-1:0] s1_sf_in, s1_sg_in, s1_m_in;

   // stage 2: N and K
   logic [PW-1:0] p_n, p_k;
   logic          s2_valid_ff;
   logic          s2_gray_ff;
   sector_type    s2_sector_ff;
   logic [CW-1:0] s2_val_ff, s2_m_ff, s2_n_ff, s2_k_ff;
   logic [CW-1:0] s2_n_in, s2_k_in;

   // output register
   logic             out_valid_ff;
   logic [PIX_W-1:0] red_ff, green_ff, blue_ff;
   logic [CW-1:0]    r_sel, g_sel, b_sel;
   logic [PIX_W-1:0] red_in, green_in, blue_in;

   assign {e_gray, e_sector, e_frac, e_sat, e_val} = ent_data;

   assign out_ready = !out_valid_ff || rsp_chan.ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign ent_ready = s1_ready;

   assign omf      = ONE - CW'(e_frac);
   assign oms      = ONE - e_sat;
   assign p_sf     = PW'(e_sat) * PW'(e_frac);
   assign p_sg     = PW'(e_sat) * PW'(omf);
   assign p_m      = PW'(e_val) * PW'(oms);
   assign s1_sf_in = CW'(p_sf >> FRAC_BITS);
   assign s1_sg_in = CW'(p_sg >> FRAC_BITS);
   assign s1_m_in  = CW'(p_m >> FRAC_BITS);

   assign p_n     = PW'(s1_val_ff) * PW'(ONE - s1_sf_ff);
   assign p_k     = PW'(s1_val_ff) * PW'(ONE - s1_sg_ff);
   assign s2_n_in = CW'(p_n >> FRAC_BITS);
   assign s2_k_in = CW'(p_k >> FRAC_BITS);

   always_comb begin
      case (s2_sector_ff)
         SEC_RED_YELLOW: begin
            r_sel = s2_val_ff; g_sel = s2_k_ff;   b_sel = s2_m_ff;
         end
         SEC_YELLOW_GREEN: begin
            r_sel = s2_n_ff;   g_sel = s2_val_ff; b_sel = s2_m_ff;
         end
         SEC_GREEN_CYAN: begin
            r_sel = s2_m_ff;   g_sel = s2_val_ff; b_sel = s2_k_ff;
         end
         SEC_CYAN_BLUE: begin
            r_sel = s2_m_ff;   g_sel = s2_n_ff;   b_sel = s2_val_ff;
         end
         SEC_BLUE_MAGENTA: begin
            r_sel = s2_k_ff;   g_sel = s2_m_ff;   b_sel = s2_val_ff;
         end
         SEC_MAGENTA_RED: begin
            r_sel = s2_val_ff; g_sel = s2_m_ff;   b_sel = s2_n_ff;
         end
         default: begin
            r_sel = s2_val_ff; g_sel = s2_m_ff;   b_sel = s2_n_ff;
         end
      endcase
      if (s2_gray_ff) begin
         r_sel = s2_val_ff;
         g_sel = s2_val_ff;
         b_sel = s2_val_ff;
      end
      red_in   = PIX_W'(r_sel);
      green_in = PIX_W'(g_sel);
      blue_in  = PIX_W'(b_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= ent_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_gray_ff   <= e_gray;
         s1_sector_ff <= e_sector;
         s1_val_ff    <= e_val;
         s1_sf_ff     <= s1_sf_in;
         s1_sg_ff     <= s1_sg_in;
         s1_m_ff      <= s1_m_in;
      end
      if (s2_ready) begin
         s2_gray_ff   <= s1_gray_ff;
         s2_sector_ff <= s1_sector_ff;
         s2_val_ff    <= s1_val_ff;
         s2_m_ff      <= s1_m_ff;
         s2_n_ff      <= s2_n_in;
         s2_k_ff      <= s2_k_in;
      end
      if (out_ready) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

   `HSVRGB_ASSERT_MSG(a_gray_equal, clock, reset, (s2_valid_ff && s2_gray_ff && out_ready) |=> ((red_ff == green_ff) && (green_ff == blue_ff)), "hsvrgb: grey pixel with unequal primaries")
   `HSVRGB_ASSERT(a_level_bound, clock, reset, out_valid_ff |-> ((red_ff <= ONE) && (green_ff <= ONE) && (blue_ff <= ONE)))

endmodule

### rtl/hsv_to_rgb_convert.sv
// Path: a req beat passes the front register, queue, two multiply stages and output
// register before rsp valid. Throughput: one pixel per cycle while the rsp side
// keeps ready high, set by the fully pipelined multiply stages; the 2-entry queue
// absorbs front/back stalls. Reset: synchronous, active high; clears all valid flags
// and queue pointers, the pipeline holds no pixel state across beats.
`timescale 1ns / 1ps

module hsv_to_rgb_convert import hsvrgb_pkg::*; #(
   parameter int unsigned FRAC_BITS = HSVRGB_FRAC_BITS
) (
   input  logic          clock,
   input  logic          reset,
   hsvrgb_req_if.sink    req_chan,
   hsvrgb_rsp_if.source  rsp_chan
);

   localparam int unsigned EW = 3 * FRAC_BITS + 6;

   logic          fq_valid, fq_ready;
   logic [EW-1:0] fq_data;
   logic          qb_valid, qb_ready;
   logic [EW-1:0] qb_data;

   hsvrgb_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .ent_valid (fq_valid),
      .ent_ready (fq_ready),
      .ent_data  (fq_data)
   );

   hsvrgb_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   hsvrgb_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_valid (qb_valid),
      .ent_ready (qb_ready),
      .ent_data  (qb_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

### verif/tb_hsv_to_rgb_convert.sv
// Self-checking testbench for the HSV to RGB pixel converter.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_convert;
   import hsvrgb_pkg::*;

   localparam int unsigned ONE_LEVEL    = 1 << HSVRGB_FRAC_BITS;
   localparam int unsigned RANDOM_PIX   = 1200;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned HOLD_AT_PIX  = 400;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef logic [PIX_W-1:0] level_type;

   typedef struct packed {
      level_type red;
      level_type green;
      level_type blue;
   } rgb_type;

   typedef struct {
      level_type hue;
      level_type sat;
      level_type bri;
      bit        typed;
      rgb_type   rgb;
   } pixel_row_type;

   logic clock;
   logic reset;

   hsvrgb_req_if req_chan ();
   hsvrgb_rsp_if rsp_chan ();

   hsv_to_rgb_convert i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rgb_type       pending_rgb[$];
   pixel_row_type directed_rows[$];
   int unsigned   pixels_sent;
   int unsigned   mismatch_count;
   int unsigned   cycle_count;
   int unsigned   send_mode;

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Fixed-point conversion: products truncate, S*F and S*(1-F) first.
   function automatic rgb_type convert_pixel(input level_type hue, input level_type sat,
                                             input level_type bri);
      int unsigned h, s, v, h6, f, m, n, k;
      sector_type  sector;
      rgb_type     px;
      s = 32'(sat);
      v = 32'(bri);
      if (s > ONE_LEVEL) s = ONE_LEVEL;
      if (v > ONE_LEVEL) v = ONE_LEVEL;
      if (s == 0) begin
         px.red   = level_type'(v);
         px.green = level_type'(v);
         px.blue  = level_type'(v);
         return px;
      end
      h = 32'(hue);
      if (h >= ONE_LEVEL) h = 0;
      h6     = h * 6;
      sector = sector_type'(h6 >> HSVRGB_FRAC_BITS);
      f      = h6 & (ONE_LEVEL - 1);
      m = (v * (ONE_LEVEL - s)) >> HSVRGB_FRAC_BITS;
      n = (v * (ONE_LEVEL - ((s * f) >> HSVRGB_FRAC_BITS))) >> HSVRGB_FRAC_BITS;
      k = (v * (ONE_LEVEL - ((s * (ONE_LEVEL - f)) >> HSVRGB_FRAC_BITS)))
          >> HSVRGB_FRAC_BITS;
      case (sector)
         SEC_RED_YELLOW: begin
            px.red = level_type'(v); px.green = level_type'(k); px.blue = level_type'(m);
         end
         SEC_YELLOW_GREEN: begin
            px.red = level_type'(n); px.green = level_type'(v); px.blue = level_type'(m);
         end
         SEC_GREEN_CYAN: begin
            px.red = level_type'(m); px.green = level_type'(v); px.blue = level_type'(k);
         end
         SEC_CYAN_BLUE: begin
            px.red = level_type'(m); px.green = level_type'(n); px.blue = level_type'(v);
         end
         SEC_BLUE_MAGENTA: begin
            px.red = level_type'(k); px.green = level_type'(m); px.blue = level_type'(v);
         end
         default: begin
            px.red = level_type'(v); px.green = level_type'(m); px.blue = level_type'(n);
         end
      endcase
      return px;
   endfunction

   // Mostly in range, some corners, some over-range (exercises bit 12 and clamping).
   function automatic level_type rand_level();
      int unsigned pick;
      level_type   lvl;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         lvl = level_type'($urandom_range(0, ONE_LEVEL));
      end else if (pick < 82) begin
         case ($urandom_range(0, 3))
            0:       lvl = '0;
            1:       lvl = level_type'(1);
            2:       lvl = level_type'(ONE_LEVEL - 1);
            default: lvl = level_type'(ONE_LEVEL);
         endcase
      end else begin
         lvl = level_type'($urandom_range(0, (1 << PIX_W) - 1));
      end
      return lvl;
   endfunction

   // Idle length: mode 0 never idles, mode 1 mostly short, mode 2 busier and longer.
   function automatic int unsigned pick_gap(input int unsigned mode);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (mode == 0) return 0;
      if (mode == 1) begin
         if (pick < 70) return 0;
         if (pick < 97) return $urandom_range(1, 3);
         return $urandom_range(10, 40);
      end
      if (pick < 30) return 0;
      if (pick < 80) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   task automatic add_row(input level_type hue, input level_type sat, input level_type bri,
                          input bit typed, input rgb_type rgb);
      pixel_row_type row;
      row.hue   = hue;
      row.sat   = sat;
      row.bri   = bri;
      row.typed = typed;
      row.rgb   = rgb;
      directed_rows.push_back(row);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   task automatic send_pixel(input level_type hue, input level_type sat,
                             input level_type bri, input bit typed,
                             input rgb_type typed_rgb);
      int unsigned gap;
      if (pixels_sent % 64 == 0) send_mode = $urandom_range(0, 2);
      gap = pick_gap(send_mode);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.hue        <= hue;
      req_chan.saturation <= sat;
      req_chan.brightness <= bri;
      do @(posedge clock); while (!req_chan.ready);
      pending_rgb.push_back(typed ? typed_rgb : convert_pixel(hue, sat, bri));
      pixels_sent++;
   endtask

   // Pixel source, then drain and verdict.
   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.hue        <= '0;
      req_chan.saturation <= '0;
      req_chan.brightness <= '0;
      pixels_sent    = 0;
      mismatch_count = 0;
      send_mode      = 0;

      // grey, clamping, wrap and primaries with typed results
      add_row(0,    0,    0,    1, '{0,    0,    0   });
      add_row(0,    0,    4096, 1, '{4096, 4096, 4096});
      add_row(8191, 0,    8191, 1, '{4096, 4096, 4096});
      add_row(4096, 0,    1234, 1, '{1234, 1234, 1234});
      add_row(0,    4096, 4096, 1, '{4096, 0,    0   });
      add_row(4096, 4096, 4096, 1, '{4096, 0,    0   });
      add_row(8191, 8191, 8191, 1, '{4096, 0,    0   });
      add_row(2048, 4096, 4096, 1, '{0,    4096, 4096});
      add_row(1000, 4096, 0,    1, '{0,    0,    0   });
      add_row(0,    1,    4096, 1, '{4096, 4095, 4095});
      // every sector and its borders, checked against the model
      add_row(1,    4096, 4096, 0, '0);
      add_row(682,  4096, 4096, 0, '0);
      add_row(683,  4096, 4096, 0, '0);
      add_row(1365, 2048, 3000, 0, '0);
      add_row(2047, 4095, 4095, 0, '0);
      add_row(2731, 4096, 2500, 0, '0);
      add_row(3413, 3000, 4096, 0, '0);
      add_row(3500, 4096, 4096, 0, '0);
      add_row(4095, 4096, 4096, 0, '0);
      add_row(5000, 1,    1,    0, '0);
      add_row(4095, 8191, 4095, 0, '0);
      add_row(1234, 4097, 4097, 0, '0);
      add_row(2222, 5555, 0,    0, '0);
      add_row(3333, 1,    8191, 0, '0);

      do @(posedge clock); while (reset);

      foreach (directed_rows[i])
         send_pixel(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].bri,
                    directed_rows[i].typed, directed_rows[i].rgb);
      repeat (RANDOM_PIX) begin
         level_type hue, sat, bri;
         hue = rand_level();
         sat = rand_level();
         bri = rand_level();
         send_pixel(hue, sat, bri, 0, '0);
      end
      req_chan.valid <= 1'b0;

      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_hsv_to_rgb_convert OK");
      end else begin
         $display("tb_hsv_to_rgb_convert NOT OK");
      end
      $finish;
   end

   // Result sink: random stalls plus one long hold-off to back the pipe up.
   initial begin : rsp_sink
      int unsigned stall_left;
      int unsigned sink_mode;
      int unsigned sink_cycles;
      bit          hold_done;
      rsp_chan.ready <= 1'b0;
      stall_left  = 0;
      sink_mode   = 0;
      sink_cycles = 0;
      hold_done   = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && pixels_sent >= HOLD_AT_PIX) begin
            hold_done  = 1;
            stall_left = HOLD_CYCLES;
         end
         if (sink_cycles % 64 == 0) sink_mode = $urandom_range(0, 2);
         sink_cycles++;
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap(sink_mode);
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      rgb_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rgb.size() == 0) begin
            report_mismatch($sformatf("rsp beat with nothing pending: rgb %0d %0d %0d",
                                      rsp_chan.red, rsp_chan.green, rsp_chan.blue));
         end else begin
            want = pending_rgb.pop_front();
            if (rsp_chan.red !== want.red)
               report_mismatch($sformatf("red: expected %0d, got %0d",
                                         want.red, rsp_chan.red));
            if (rsp_chan.green !== want.green)
               report_mismatch($sformatf("green: expected %0d, got %0d",
                                         want.green, rsp_chan.green));
            if (rsp_chan.blue !== want.blue)
               report_mismatch($sformatf("blue: expected %0d, got %0d",
                                         want.blue, rsp_chan.blue));
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_rgb.size());
      $display("tb_hsv_to_rgb_convert NOT OK");
      $finish;
   end

endmodule
